// ----- src/assert_macros.svh -----
// Assertion helper macros for the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, disabled during rst.
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, disabled during rst.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pdmpc_pkg.sv -----
// Types, constants, microcode ROM and helpers for the PD position controller.
`timescale 1ns / 1ps
`default_nettype none
package pdmpc_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int DIV_STEPS   = 32;
  localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);

  typedef struct packed {
    logic        func;
    logic        channel_b_level;
    logic [15:0] elapsed_ms;
  } item_t;

  typedef struct packed {
    logic signed [15:0] drive_level;
    logic               reverse_drive;
    logic [7:0]         duty;
    logic signed [31:0] pulse_total;
  } result_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TARGET_ANGLE,
    REG_P_GAIN,
    REG_D_GAIN,
    REG_ANGLE_PER_COUNT
  } cfg_reg_t;

  localparam logic signed [31:0] TARGET_ANGLE_RST    = 32'sd205887;
  localparam logic [15:0]        P_GAIN_RST          = 16'd410;
  localparam logic [15:0]        D_GAIN_RST          = 16'd410;
  localparam logic [23:0]        ANGLE_PER_COUNT_RST = 24'd167324;

  // Datapath operation of one microcode step.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_IDLE,
    OP_MUL_ANGLE,
    OP_ANGLE,
    OP_ERR,
    OP_DIFF,
    OP_DIV_STEP,
    OP_DERIV,
    OP_MUL_P,
    OP_MUL_D,
    OP_ADD,
    OP_OUT
  } op_t;

  // Jump taken when the condition holds, else fall through to the next step.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_TICK,
    COND_DIV_BUSY,
    COND_OUT_FULL
  } cond_t;

  typedef logic [3:0] step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  localparam step_t ST_IDLE = 4'd0;
  localparam step_t ST_DIV  = 4'd5;
  localparam step_t ST_OUT  = 4'd10;

  function automatic ctrl_t microcode(input step_t s);
    ctrl_t cw;
    case (s)
      4'd0:    cw = '{OP_IDLE,      COND_NO_TICK,  ST_IDLE};
      4'd1:    cw = '{OP_MUL_ANGLE, COND_NEVER,    ST_IDLE};
      4'd2:    cw = '{OP_ANGLE,     COND_NEVER,    ST_IDLE};
      4'd3:    cw = '{OP_ERR,       COND_NEVER,    ST_IDLE};
      4'd4:    cw = '{OP_DIFF,      COND_NEVER,    ST_IDLE};
      4'd5:    cw = '{OP_DIV_STEP,  COND_DIV_BUSY, ST_DIV};
      4'd6:    cw = '{OP_DERIV,     COND_NEVER,    ST_IDLE};
      4'd7:    cw = '{OP_MUL_P,     COND_NEVER,    ST_IDLE};
      4'd8:    cw = '{OP_MUL_D,     COND_NEVER,    ST_IDLE};
      4'd9:    cw = '{OP_ADD,       COND_NEVER,    ST_IDLE};
      4'd10:   cw = '{OP_OUT,       COND_OUT_FULL, ST_OUT};
      default: cw = '{OP_NONE,      COND_ALWAYS,   ST_IDLE};
    endcase
    return cw;
  endfunction

  // Saturate a sign-extended value to 32-bit signed.
  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if ((&v[48:31]) || !(|v[48:31])) begin
      r = signed'(v[31:0]);
    end else if (v[48]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/pd_motor_position_controller_core.sv -----
// Top level of the PD motor position controller: microcoded sequencer and datapath.
`timescale 1ns / 1ps
`default_nettype none
// Counts encoder pulses and closes a PD position loop in fixed point (angles
// Q16.16, gains Q4.12, output Q1.15). An encoder-edge word (func = 0) is taken
// whenever the block is idle and yields no result. A control-tick word
// (func = 1) runs a microprogram that occupies the block from acceptance to
// the return to idle; the bit-serial restoring divider forms the derivative,
// and one shared 32x25 multiplier serves the angle and both gain products. One
// word is in work at a time. The finished result sits in an output register,
// so the next word is accepted while it waits; a new tick stalls only at its
// last step if that register is still full. Configuration is written through
// cfg_we/cfg_index/cfg_data.
module pd_motor_position_controller_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  pdmpc_pkg::item_t                     item,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output pdmpc_pkg::result_t                   result,
  input  logic                                 cfg_we,
  input  logic [pdmpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pdmpc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pdmpc_pkg::*;

  // Configuration
  logic signed [31:0] target_angle;
  logic [15:0]        p_gain;
  logic [15:0]        d_gain;
  logic [23:0]        angle_per_count;

  // Architectural state
  logic [COUNT_WIDTH-1:0] pulse_count;
  logic signed [31:0]     previous_error;

  // Sequencer
  step_t pc;
  step_t pc_next;
  ctrl_t cw;
  logic  cond_hit;
  logic  out_full;
  logic  load_out;

  // Datapath registers
  logic [15:0]        elapsed;
  logic signed [56:0] prod;
  logic signed [31:0] angle;
  logic signed [31:0] err;
  logic signed [31:0] deriv;
  logic signed [48:0] acc;
  logic               diff_neg;
  logic [31:0]        div_quo;
  logic [15:0]        div_rem;
  logic [4:0]         div_cnt;

  // Datapath combinational
  logic signed [COUNT_WIDTH-1:0] count_s;
  logic signed [31:0] count_ext;
  logic signed [31:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [56:0] mul_out;
  logic signed [32:0] err_w;
  logic signed [32:0] diff_w;
  logic [31:0]        diff_mag;
  logic [16:0]        div_shift;
  logic [16:0]        div_sub;
  logic               div_ge;
  logic signed [32:0] quo_s;
  logic signed [35:0] u_wide;
  logic signed [16:0] u_val;
  logic [15:0]        u_mag;
  logic [23:0]        duty_w;
  logic signed [15:0] drive_w;

  assign count_s   = signed'(pulse_count);
  assign count_ext = 32'(count_s);

  // ---------------- sequencer ----------------
  assign cw       = microcode(pc);
  assign out_full = result_valid && !result_ready;

  always_comb begin
    case (cw.cond)
      COND_NEVER:    cond_hit = 1'b0;
      COND_ALWAYS:   cond_hit = 1'b1;
      COND_NO_TICK:  cond_hit = !(item_valid && item.func);
      COND_DIV_BUSY: cond_hit = (div_cnt != DIV_LAST);
      COND_OUT_FULL: cond_hit = out_full;
      default:       cond_hit = 1'b1;
    endcase
    pc_next = cond_hit ? cw.target : step_t'(pc + 4'd1);
  end

  always_comb begin
    item_ready = (cw.op == OP_IDLE);
    load_out   = (cw.op == OP_OUT) && !out_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      target_angle    <= TARGET_ANGLE_RST;
      p_gain          <= P_GAIN_RST;
      d_gain          <= D_GAIN_RST;
      angle_per_count <= ANGLE_PER_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TARGET_ANGLE:    target_angle    <= signed'(cfg_data[31:0]);
        REG_P_GAIN:          p_gain          <= cfg_data[15:0];
        REG_D_GAIN:          d_gain          <= cfg_data[15:0];
        REG_ANGLE_PER_COUNT: angle_per_count <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // ---------------- datapath combinational ----------------
  // One shared signed multiplier: count x rad/count, or gain x error term.
  always_comb begin
    case (cw.op)
      OP_MUL_ANGLE: begin
        mul_a = count_ext;
        mul_b = signed'({1'b0, angle_per_count});
      end
      OP_MUL_D: begin
        mul_a = deriv;
        mul_b = 25'(signed'({1'b0, d_gain}));
      end
      default: begin
        mul_a = err;
        mul_b = 25'(signed'({1'b0, p_gain}));
      end
    endcase
  end

  assign mul_out = 57'(mul_a) * 57'(mul_b);

  assign err_w    = 33'(angle) - 33'(target_angle);
  assign diff_w   = 33'(err) - 33'(previous_error);
  assign diff_mag = diff_w[32] ? 32'(-diff_w) : diff_w[31:0];

  // Restoring divide step; remainder stays below elapsed.
  assign div_shift = {div_rem, div_quo[31]};
  assign div_ge    = (div_shift >= {1'b0, elapsed});
  assign div_sub   = div_shift - {1'b0, elapsed};

  assign quo_s = diff_neg ? -signed'({1'b0, div_quo}) : signed'({1'b0, div_quo});

  // Output stage: floor shift by 13, clamp to +-1.0, duty = |u|*255 >> 15.
  always_comb begin
    u_wide = signed'(acc[48:13]);
    if (u_wide > 36'sd32768) begin
      u_val = 17'sd32768;
    end else if (u_wide < -36'sd32768) begin
      u_val = -17'sd32768;
    end else begin
      u_val = 17'(u_wide);
    end
    u_mag   = u_val[16] ? 16'(-u_val) : u_val[15:0];
    duty_w  = {u_mag, 8'd0} - 24'(u_mag);
    drive_w = (u_val > 17'sd32767) ? 16'sh7FFF : signed'(u_val[15:0]);
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_count    <= '0;
      previous_error <= '0;
    end else begin
      case (cw.op)
        OP_IDLE: begin
          if (item_valid && !item.func) begin
            if (item.channel_b_level) begin
              pulse_count <= pulse_count - COUNT_WIDTH'(1);
            end else begin
              pulse_count <= pulse_count + COUNT_WIDTH'(1);
            end
          end
        end
        OP_DIFF: previous_error <= err;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cw.op)
      OP_IDLE: begin
        if (item_valid && item.func) begin
          elapsed <= (item.elapsed_ms == 16'd0) ? 16'd1 : item.elapsed_ms;
        end
      end
      OP_MUL_ANGLE: prod  <= mul_out;
      OP_ANGLE:     angle <= sat32(signed'(prod[56:8]));
      OP_ERR:       err   <= sat32(49'(err_w));
      OP_DIFF: begin
        diff_neg <= diff_w[32];
        div_quo  <= diff_mag;
        div_rem  <= '0;
        div_cnt  <= '0;
      end
      OP_DIV_STEP: begin
        div_rem <= div_ge ? div_sub[15:0] : div_shift[15:0];
        div_quo <= {div_quo[30:0], div_ge};
        div_cnt <= div_cnt + 5'd1;
      end
      OP_DERIV:     deriv <= sat32(49'(quo_s));
      OP_MUL_P:     prod  <= mul_out;
      OP_MUL_D: begin
        acc  <= signed'(prod[48:0]);
        prod <= mul_out;
      end
      OP_ADD:       acc <= acc + signed'(prod[48:0]);
      default: ;
    endcase
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.drive_level   <= drive_w;
      result.reverse_drive <= (u_val > 17'sd0);
      result.duty          <= duty_w[22:15];
      result.pulse_total   <= count_ext;
    end
  end

endmodule
`default_nettype wire

// ----- src/pdmpc_checker.sv -----
// Port-level checker for the PD position controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pdmpc_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input pdmpc_pkg::item_t   item,
  input logic               result_valid,
  input logic               result_ready,
  input pdmpc_pkg::result_t result
);

  logic in_take;
  logic out_stall;
  logic drive_pos;
  logic drive_zero;

  assign in_take    = item_valid && item_ready;
  assign out_stall  = result_valid && !result_ready;
  assign drive_pos  = (result.drive_level > 16'sd0);
  assign drive_zero = (result.drive_level == 16'sd0);

  // A stalled word holds.
  `ASSERT_NEXT(a_result_hold, out_stall, result_valid && $stable(result), "stalled word changed")

  // An encoder edge never produces a word.
  `ASSERT_NEXT(a_edge_silent, in_take && !item.func, !$rose(result_valid), "word after edge")

  // A control tick keeps the block busy afterwards.
  `ASSERT_NEXT(a_tick_busy, in_take && item.func, !item_ready, "input taken during tick")

  // Direction follows the sign of the drive level.
  `ASSERT_NOW(a_dir_sign, result_valid, result.reverse_drive == drive_pos, "direction vs drive sign")

  // Zero drive means zero duty.
  `ASSERT_NOW(a_zero_duty, result_valid && drive_zero, result.duty == 8'd0, "duty at zero drive")

endmodule

bind pd_motor_position_controller_core pdmpc_checker u_pdmpc_checker (.*);
`default_nettype wire
